@@ sv/mf3_pkg.sv @@
package mf3_pkg;

    localparam int PIX_W     = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_N     = 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Smallest legal frame dimension and the first column/row with a full window.
    localparam int MIN_DIM  = 3;
    localparam int WIN_EDGE = 2;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] win_t;

    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } sort3_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t   lo1;
        pix_t   hi1;
        pix_t   t;
        sort3_t s;
        lo1   = min2(a, b);
        hi1   = max2(a, b);
        s.hi  = max2(hi1, c);
        t     = min2(hi1, c);
        s.lo  = min2(lo1, t);
        s.mid = max2(lo1, t);
        return s;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

@@ sv/mf3_median.sv @@
module mf3_median
    import mf3_pkg::*;
#(
    parameter int META_W = 27
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  win_t              in_win,
    input  logic [META_W-1:0] in_meta,
    output logic              out_valid,
    input  logic              out_ready,
    output pix_t              out_median,
    output logic [META_W-1:0] out_meta
);

    // Median of nine: sort each row of three, then take the largest low,
    // the median of the middles and the smallest high, and finally the
    // median of those three values.
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              rdy1, rdy2, rdy3, rdy4;
    win_t              win1_reg;
    sort3_t [2:0]      rows2_reg;
    pix_t   [2:0]      cand3_reg;
    pix_t              med4_reg;
    logic [META_W-1:0] meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    sort3_t [2:0]      rows2_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rows2_next[k] = sort3(win1_reg[3*k], win1_reg[3*k+1], win1_reg[3*k+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            win1_reg  <= in_win;
            meta1_reg <= in_meta;
        end
        if (rdy2 && v1_reg) begin
            rows2_reg <= rows2_next;
            meta2_reg <= meta1_reg;
        end
        if (rdy3 && v2_reg) begin
            cand3_reg[0] <= max2(max2(rows2_reg[0].lo, rows2_reg[1].lo), rows2_reg[2].lo);
            cand3_reg[1] <= med3(rows2_reg[0].mid, rows2_reg[1].mid, rows2_reg[2].mid);
            cand3_reg[2] <= min2(min2(rows2_reg[0].hi, rows2_reg[1].hi), rows2_reg[2].hi);
            meta3_reg    <= meta2_reg;
        end
        if (rdy4 && v3_reg) begin
            med4_reg  <= med3(cand3_reg[0], cand3_reg[1], cand3_reg[2]);
            meta4_reg <= meta3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign out_median = med4_reg;
    assign out_meta   = meta4_reg;

endmodule

@@ sv/median_filter_3x3.sv @@
// 3x3 median filter for a raster-order stream of 8-bit gray pixels. Each input
// beat carries one pixel; for every pixel that completes a full 3x3 window
// (column and row both at least two) one output beat carries the median of the
// nine window pixels with the column and row of the window center, and the
// result of the last pixel of the frame has end_of_frame set. Border pixels
// produce no output beat. The block takes one pixel per clock cycle when the
// output side keeps up; each pixel passes the line-store read stage and then
// the sorting pipeline before its result appears. The rate is set by the two
// line stores, each a single memory that does one read and one write per
// cycle: the read for a pixel is issued when it is accepted and its write-back
// happens when the pixel leaves the read stage, always at a different column
// than the read then being issued. The line stores are not cleared after
// reset; no emitted result ever depends on an entry not yet written. Writing
// frame_width or frame_height restarts the frame at column 0, row 0; the user
// must see that configuration is written only while the block is idle, as the
// block does not enforce it. Width clamps to [3, MAX_WIDTH], height to at least 3.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port.
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_wdata,
    // Pixel input channel.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [PIX_W-1:0]             s_pixel_value,
    // Result channel.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [PIX_W-1:0]             m_median_value,
    output logic [$clog2(MAX_WIDTH)-1:0] m_center_col,
    output logic [FH_W-1:0]              m_center_row,
    output logic                         m_end_of_frame
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    // Width used for comparing the width register against the column range.
    localparam int EW     = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int META_W = 1 + FH_W + COL_W;

    // Configuration registers and frame position.
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg;
    logic [FH_W-1:0]  row_reg;

    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    eff_w;
    logic [EW-1:0]    last_col;
    logic [FH_W-1:0]  last_row;
    logic             at_last_col;
    logic             at_last_row;

    // The two line stores and their registered read data.
    pix_t             line_upper_mem [MAX_WIDTH];
    pix_t             line_middle_mem [MAX_WIDTH];
    pix_t             up_rd_reg;
    pix_t             mid_rd_reg;

    // Read stage: the pixel whose line-store read is in flight.
    logic              a_valid_reg;
    logic              a_emit_reg;
    pix_t              a_pixel_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [META_W-1:0] a_meta_reg;

    win_t             win_reg;
    win_t             win_next;

    logic             s_fire;
    logic             a_move;
    logic             med_in_ready;
    logic [META_W-1:0] med_out_meta;

    // Effective frame size.
    always_comb begin
        fw_ext = EW'(frame_width_reg);
        if (fw_ext < EW'(MIN_DIM)) begin
            eff_w = EW'(MIN_DIM);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        last_col = eff_w - 1'b1;
        if (frame_height_reg < FH_W'(MIN_DIM)) begin
            last_row = FH_W'(MIN_DIM - 1);
        end else begin
            last_row = frame_height_reg - 1'b1;
        end
    end

    assign at_last_col = (EW'(col_reg) == last_col);
    assign at_last_row = (row_reg == last_row);

    // The read stage hands a pixel on when it needs no result or the median
    // pipeline can take its window.
    assign a_move  = a_valid_reg && (!a_emit_reg || med_in_ready);
    assign s_ready = !a_valid_reg || a_move;
    assign s_fire  = s_valid && s_ready;

    // Configuration and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(1024);
            frame_height_reg <= FH_W'(1024);
            col_reg          <= '0;
            row_reg          <= '0;
        end else if (cfg_wr_en && (cfg_index == REG_FRAME_WIDTH ||
                                   cfg_index == REG_FRAME_HEIGHT)) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wdata[FW_W-1:0];
            end else begin
                frame_height_reg <= cfg_wdata[FH_W-1:0];
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            if (at_last_col) begin
                col_reg <= '0;
                row_reg <= at_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Read stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_ready) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_pixel_reg <= s_pixel_value;
            a_col_reg   <= col_reg;
            a_emit_reg  <= (col_reg >= COL_W'(WIN_EDGE)) && (row_reg >= FH_W'(WIN_EDGE));
            a_meta_reg  <= {at_last_col && at_last_row, row_reg - 1'b1, col_reg - 1'b1};
        end
    end

    // Line stores: read at acceptance, write back when the pixel leaves the read stage. The upper
    // line takes the old middle value and the middle line takes the new pixel.
    always_ff @(posedge aclk) begin
        if (a_move) begin
            line_upper_mem[a_col_reg]  <= mid_rd_reg;
            line_middle_mem[a_col_reg] <= a_pixel_reg;
        end
        if (s_fire) begin
            up_rd_reg  <= line_upper_mem[col_reg];
            mid_rd_reg <= line_middle_mem[col_reg];
        end
    end

    // Window: rows are upper, middle, current; the last column is the newest.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[3*k]   = win_reg[3*k+1];
            win_next[3*k+1] = win_reg[3*k+2];
        end
        win_next[2] = up_rd_reg;
        win_next[5] = mid_rd_reg;
        win_next[8] = a_pixel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (a_move) begin
            win_reg <= win_next;
        end
    end

    mf3_median #(
        .META_W (META_W)
    ) u_median (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (a_valid_reg && a_emit_reg),
        .in_ready   (med_in_ready),
        .in_win     (win_next),
        .in_meta    (a_meta_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_median (m_median_value),
        .out_meta   (med_out_meta)
    );

    assign m_center_col   = med_out_meta[COL_W-1:0];
    assign m_center_row   = med_out_meta[COL_W +: FH_W];
    assign m_end_of_frame = med_out_meta[META_W-1];

`ifndef SYNTHESIS
    // The position counters never leave the effective frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (EW'(col_reg) <= last_col) && (row_reg <= last_row))
        else $error("frame position outside the effective frame");

    // A write-back never meets the read issued in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && a_move) |-> (a_col_reg != col_reg))
        else $error("line store read and write collide");

    // Every result lies inside the border.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_center_col != '0) && (m_center_row != '0))
        else $error("result emitted for a border position");

    // An accepted pixel always occupies the read stage in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> a_valid_reg)
        else $error("accepted pixel lost in the read stage");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the 3x3 median filter.
module testbench
    import mf3_pkg::*;
();

    // The block is built for the largest line it supports.
    localparam int MAX_W = 1024;
    localparam int COL_W = $clog2(MAX_W);

    // Register indexes past the end of the register list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    // A moderately wide line, written with junk in the bits above the width register.
    localparam int unsigned      WIDE_PIXELS = 64;
    localparam logic [CFG_W-1:0] WIDE_LINE   = {5'b10101, 11'(WIDE_PIXELS)};

    localparam int unsigned PIPE_FLUSH   = 16;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 160;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    // Idle percentages of the sender and the receiver in each random phase.
    localparam int unsigned SRC_IDLE [4]  = '{0, 64, 0, 36};
    localparam int unsigned SINK_STALL [4] = '{0, 0, 64, 36};

    typedef struct packed {
        pix_t             median_value;
        logic [COL_W-1:0] center_col;
        logic [FH_W-1:0]  center_row;
        logic             end_of_frame;
    } median_beat_t;

    localparam median_beat_t NO_BEAT = '0;

    typedef enum logic [1:0] {
        ROW_REG_WRITE,
        ROW_PIXEL,
        ROW_PIXEL_KNOWN
    } row_kind_t;

    typedef enum logic [1:0] {
        STYLE_UNIFORM,
        STYLE_EXTREME,
        STYLE_CLUSTER
    } pix_style_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        pix_t                 pix;
        median_beat_t         want;
    } stim_row_t;

    // Directed opening. The first frame is 3x3 after both dimensions clamp up to the
    // minimum, so only its ninth pixel completes a window; with every pixel at full
    // scale the median is full scale at the center, flagged as end of frame. The second
    // frame alternates the extremes and is checked by the predictor. Then writes to the
    // unused indexes and all-ones writes that clamp the width to the largest line.
    localparam int N_DIRECTED = 27;
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ROW_REG_WRITE,   REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_REG_WRITE,   REG_FRAME_HEIGHT, 16'h0002, 8'h00, NO_BEAT},
        '{ROW_REG_WRITE,   REG_UNUSED_2,     16'hFFFF, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL_KNOWN, REG_FRAME_WIDTH,  16'h0000, 8'hFF,
          '{8'hFF, 10'd1, 16'd1, 1'b1}},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hFF, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h00, NO_BEAT},
        '{ROW_REG_WRITE,   REG_UNUSED_3,     16'h0000, 8'h00, NO_BEAT},
        '{ROW_REG_WRITE,   REG_FRAME_WIDTH,  16'hFFFF, 8'h00, NO_BEAT},
        '{ROW_REG_WRITE,   REG_FRAME_HEIGHT, 16'hFFFF, 8'h00, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h5A, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'hA5, NO_BEAT},
        '{ROW_PIXEL,       REG_FRAME_WIDTH,  16'h0000, 8'h80, NO_BEAT}
    };

    // Every input of the block starts at a known value.
    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_value = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [PIX_W-1:0]     m_median_value;
    logic [COL_W-1:0]     m_center_col;
    logic [FH_W-1:0]      m_center_row;
    logic                 m_end_of_frame;

    median_filter_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_median_value(m_median_value),
        .m_center_col  (m_center_col),
        .m_center_row  (m_center_row),
        .m_end_of_frame(m_end_of_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Shared between the stimulus, the receiver and the checker.
    median_beat_t pending_medians [$];
    int unsigned  fail_count     = 0;
    int unsigned  src_idle_pct   = 0;
    int unsigned  sink_stall_pct = 0;
    int unsigned  hold_requests  = 0;
    int unsigned  hold_served    = 0;

    // Predictor state: its own copy of the registers, the line stores, the window
    // and the raster position of the next pixel.
    logic [FW_W-1:0] model_width;
    logic [FH_W-1:0] model_height;
    pix_t            upper_line [MAX_W];
    pix_t            middle_line [MAX_W];
    pix_t            window_px [WIN_N];
    int unsigned     next_col;
    int unsigned     next_row;

    task automatic reset_model();
        model_width  = FW_W'(1024);
        model_height = FH_W'(1024);
        next_col     = 0;
        next_row     = 0;
        foreach (window_px[i]) window_px[i] = '0;
        foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
    endtask

    function automatic int unsigned eff_width();
        if (model_width < MIN_DIM) return MIN_DIM;
        if (model_width > MAX_W) return MAX_W;
        return int'(model_width);
    endfunction

    function automatic int unsigned eff_height();
        if (model_height < MIN_DIM) return MIN_DIM;
        return int'(model_height);
    endfunction

    // A write to either dimension restarts the raster at the origin. The window is
    // left as it is; writes to indexes past the list change nothing at all.
    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH: begin
                model_width = data[FW_W-1:0];
                next_col    = 0;
                next_row    = 0;
            end
            REG_FRAME_HEIGHT: begin
                model_height = data[FH_W-1:0];
                next_col     = 0;
                next_row     = 0;
            end
            default: ;
        endcase
    endtask

    // Median of the nine window pixels by insertion sort.
    function automatic pix_t window_median();
        pix_t sorted [WIN_N];
        pix_t key;
        int   j;
        foreach (window_px[i]) sorted[i] = window_px[i];
        for (int i = 1; i < WIN_N; i++) begin
            key = sorted[i];
            j   = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        return sorted[WIN_N / 2];
    endfunction

    // Feeds one pixel through the predictor and says whether it completes a window.
    task automatic predict_median(input pix_t pix, output bit emits,
                                  output median_beat_t beat);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pix_t        up_px;
        pix_t        mid_px;
        w = eff_width();
        h = eff_height();
        c = (next_col >= w) ? 0 : next_col;
        r = (next_row >= h) ? 0 : next_row;
        up_px  = upper_line[c];
        mid_px = middle_line[c];
        // Window rows are upper, middle, current; the right-hand column is the newest.
        for (int k = 0; k < 3; k++) begin
            window_px[k * 3 + 0] = window_px[k * 3 + 1];
            window_px[k * 3 + 1] = window_px[k * 3 + 2];
        end
        window_px[2] = up_px;
        window_px[5] = mid_px;
        window_px[8] = pix;
        upper_line[c]  = mid_px;
        middle_line[c] = pix;
        emits = (c >= WIN_EDGE) && (r >= WIN_EDGE);
        beat  = NO_BEAT;
        if (emits) begin
            beat.median_value = window_median();
            beat.center_col   = COL_W'(c - 1);
            beat.center_row   = FH_W'(r - 1);
            beat.end_of_frame = (c == w - 1) && (r == h - 1);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    // The receiver. Normally it stalls at random at the phase's rate; on request it
    // holds ready low for a long stretch while the sender keeps offering pixels, so
    // that the pipeline fills and the input side has to stall.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Every accepted result beat is matched against the oldest pending median.
    always @(posedge aclk) begin : result_check
        median_beat_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_medians.size() == 0) begin
                $error("result beat with no pending median: value %0d col %0d row %0d",
                       m_median_value, m_center_col, m_center_row);
                fail_count++;
            end else begin
                want = pending_medians.pop_front();
                if (m_median_value !== want.median_value) begin
                    $error("median_value: expected %0d, actual %0d",
                           want.median_value, m_median_value);
                    fail_count++;
                end
                if (m_center_col !== want.center_col) begin
                    $error("center_col: expected %0d, actual %0d",
                           want.center_col, m_center_col);
                    fail_count++;
                end
                if (m_center_row !== want.center_row) begin
                    $error("center_row: expected %0d, actual %0d",
                           want.center_row, m_center_row);
                    fail_count++;
                end
                if (m_end_of_frame !== want.end_of_frame) begin
                    $error("end_of_frame: expected %0d, actual %0d",
                           want.end_of_frame, m_end_of_frame);
                    fail_count++;
                end
            end
        end
    end

    // Offers one pixel beat and waits for it to be taken. A random idle gap goes
    // first, at the sender's idle rate. When a known result is given it stands in
    // for the predicted one.
    task automatic send_pixel(input pix_t pix, input bit known, input median_beat_t want);
        int unsigned  gap;
        bit           emits;
        median_beat_t beat;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= pix;
        do @(posedge aclk); while (!s_ready);
        predict_median(pix, emits, beat);
        if (known) pending_medians.insert(pending_medians.size(), want);
        else if (emits) pending_medians.insert(pending_medians.size(), beat);
    endtask

    function automatic pix_t pick_pixel(input pix_style_t style, input pix_t base);
        case (style)
            STYLE_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            STYLE_CLUSTER: return base + pix_t'($urandom_range(3));
            default:       return pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_run(input int unsigned count, input pix_style_t style);
        pix_t base;
        base = pix_t'($urandom);
        repeat (count) send_pixel(pick_pixel(style, base), 1'b0, NO_BEAT);
    endtask

    // Brings the block to rest: no beat offered, every pending median delivered,
    // then a few more cycles for border pixels still in the pipeline.
    task automatic settle();
        int unsigned waited;
        s_valid <= 1'b0;
        waited = 0;
        while (pending_medians.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_medians.size() != 0) begin
            $error("%0d pending medians never arrived", pending_medians.size());
            fail_count++;
            pending_medians.delete();
        end
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    // One register write; the enable drops in the cycle after it is raised, so that back-to-back
    // writes never touch the enable twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_reg_write(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One random stretch: new frame dimensions, then one or two whole frames, often
    // with a partial frame on top that the next write cuts short. Widths are small,
    // with now and then a value that clamps up; heights now and then clamp up or are
    // the largest possible, in which case only a few rows go through. Some stretches
    // pause partway for a write to an unused index, which must not restart the frame.
    task automatic random_segment(inout int unsigned sent);
        int unsigned      w_raw;
        int unsigned      h_raw;
        int unsigned      frame_len;
        int unsigned      count;
        int unsigned      half;
        logic [CFG_W-1:0] w_data;
        pix_style_t       style;
        settle();
        w_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(10, 3);
        case ($urandom_range(11))
            0:       h_raw = $urandom_range(2);
            1:       h_raw = 65535;
            default: h_raw = $urandom_range(7, 3);
        endcase
        // Bits above the width register are junk and must be ignored.
        w_data = {5'($urandom), 11'(w_raw)};
        if ($urandom_range(1)) begin
            write_reg(REG_FRAME_WIDTH, w_data);
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h_raw));
        end else begin
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h_raw));
            write_reg(REG_FRAME_WIDTH, w_data);
        end
        frame_len = eff_width() * eff_height();
        if (h_raw == 65535) begin
            count = eff_width() * $urandom_range(12, 4);
        end else begin
            count = frame_len * $urandom_range(2, 1);
            if ($urandom_range(2) == 0) count += $urandom_range(frame_len - 1, 1);
        end
        style = pix_style_t'($urandom_range(2));
        if ($urandom_range(3) == 0) begin
            half = $urandom_range(count - 1, 1);
            send_run(half, style);
            settle();
            write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_W'($urandom));
            send_run(count - half, style);
        end else begin
            send_run(count, style);
        end
        sent += count;
    endtask

    initial begin : stimulus
        int unsigned sent;
        stim_row_t   row;
        reset_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            case (row.kind)
                ROW_REG_WRITE: begin
                    settle();
                    write_reg(row.idx, row.data);
                end
                ROW_PIXEL_KNOWN: send_pixel(row.pix, 1'b1, row.want);
                default:         send_pixel(row.pix, 1'b0, NO_BEAT);
            endcase
        end

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            src_idle_pct   = SRC_IDLE[phase];
            sink_stall_pct = SINK_STALL[phase];
            if (phase == 0) begin
                // One full frame of a wider line, three rows tall, written with junk
                // above the width register.
                write_reg(REG_FRAME_WIDTH, WIDE_LINE);
                write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
                send_run(3 * WIDE_PIXELS, STYLE_UNIFORM);
                // Narrow, tall frame with the receiver held off: about half the pixels
                // yield a result, so the block backs up and stalls its input.
                settle();
                write_reg(REG_FRAME_WIDTH, CFG_W'(4));
                write_reg(REG_FRAME_HEIGHT, CFG_W'(40));
                hold_requests++;
                send_run(120, STYLE_UNIFORM);
            end
            sent = 0;
            while (sent < PHASE_ITEMS) random_segment(sent);
        end

        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Guard against a hang: far longer than the slowest correct run.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
